/* sv/i2cbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbe_pkg: shared types and constants of the I2C master byte engine
// Command codes, timer width and the request and result item records.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   localparam int TIMER_W = 16;

   localparam logic [TIMER_W-1:0] HALF_PERIOD_RESET = TIMER_W'(500);

   typedef enum logic [2:0] {
      MODE_START     = 3'd0,
      MODE_STOP      = 3'd1,
      MODE_WRITE     = 3'd2,
      MODE_READ_ACK  = 3'd3,
      MODE_READ_NACK = 3'd4
   } mode_type;

   // one bus tick as it arrives on the request channel
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_item_type;

   // pin levels and status after one tick
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_ok;
   } rsp_item_type;

endpackage

/* sv/i2c_master_byte_engine_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core: single-master I2C byte engine
// Each request transfer is one bus tick with an optional command and the
// sampled SDA level; each response transfer gives the pin drive and status.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one transfer per bus tick. req_cmd_valid marks a
//    command (start, stop, write byte, read then ACK, read then NACK); it is
//    ignored while the engine is busy, and unknown mode codes are ignored.
//  - Response channel (rsp_*): exactly one transfer per request, in order:
//    SCL/SDA levels, SDA drive enable, busy, done pulse, last read byte and
//    last write ACK status.
//  - csr_we/csr_wdata load half_period (ticks per bus phase and ACK poll
//    limit); write it only while no tick is in flight. Zero acts as one.
//  - Path: a tick passes the input register, then the sequencer and the
//    result register, from which its response is offered.
//  - Throughput: one tick per clock while rsp_ready is high; the sequencer advances once per tick.
//  - Reset: bus idle (SCL and SDA high, SDA driven), not busy, rx byte and
//    ACK flag zero, half_period 500, both register stages empty.
//  - Stall: while rsp_ready is low a full result register stays put and the
//    sequencer holds (an empty one still takes one result); an empty input
//    register still takes one tick, a full one drops req_ready in the same cycle.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core
   import i2cbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd_valid,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_tx_byte,
   input  logic               req_sda_in,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_scl_out,
   output logic               rsp_sda_out,
   output logic               rsp_sda_drive,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic [7:0]         rsp_rx_byte,
   output logic               rsp_ack_ok,
   // configuration
   input  logic               csr_we,
   input  logic [TIMER_W-1:0] csr_wdata
);

   req_item_type       req_item;
   req_item_type       tick_item;
   logic               tick_valid;
   logic               res_ready;
   logic               step;
   rsp_item_type       res_item;
   rsp_item_type       rsp_item;
   logic [TIMER_W-1:0] half_period_ff;

   // half-period register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         half_period_ff <= csr_wdata;
      end
   end

   assign req_item.cmd_valid = req_cmd_valid;
   assign req_item.mode      = req_mode;
   assign req_item.tx_byte   = req_tx_byte;
   assign req_item.sda_in    = req_sda_in;

   i2cbe_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_item    (req_item),
      .item_valid (tick_valid),
      .item       (tick_item),
      .item_take  (res_ready)
   );

   // the sequencer advances only when its result has a place to go
   assign step = tick_valid && res_ready;

   i2cbe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (tick_item),
      .half_period (half_period_ff),
      .result      (res_item)
   );

   i2cbe_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tick_valid),
      .in_ready  (res_ready),
      .in_item   (res_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_scl_out   = rsp_item.scl_out;
   assign rsp_sda_out   = rsp_item.sda_out;
   assign rsp_sda_drive = rsp_item.sda_drive;
   assign rsp_busy_res  = rsp_item.busy_res;
   assign rsp_done_res  = rsp_item.done_res;
   assign rsp_rx_byte   = rsp_item.rx_byte;
   assign rsp_ack_ok    = rsp_item.ack_ok;

endmodule

/* sv/i2cbe_in_reg.sv */
// ----------------------------------------------------------------------------
// i2cbe_in_reg: request input register
// Holds one accepted tick until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cbe_in_reg
   import i2cbe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         item_valid,
   output req_item_type item,
   input  logic         item_take
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready   = !valid_ff || item_take;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !item_take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

/* sv/i2cbe_seq.sv */
// ----------------------------------------------------------------------------
// i2cbe_seq: I2C phase sequencer
// Advances the bus state by one tick per step and forms the tick's result.
// ----------------------------------------------------------------------------
module i2cbe_seq
   import i2cbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  req_item_type       item,
   input  logic [TIMER_W-1:0] half_period,
   output rsp_item_type       result
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_SP_C,
      PH_WR_DATA, PH_WR_HIGH, PH_WR_LOW, PH_ACK_HIGH, PH_ACK_POLL, PH_ACK_LOW,
      PH_RD_HIGH, PH_RD_LOW, PH_RA_DATA, PH_RA_HIGH, PH_RA_LOW
   } phase_type;

   phase_type          phase_ff, phase_in, enter_ph;
   logic [TIMER_W-1:0] ptimer_ff, ptimer_in;
   logic [TIMER_W-1:0] atimer_ff, atimer_in, atimer_dec;
   logic [2:0]         bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic [2:0]         mode_ff, mode_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               sden_ff, sden_in;
   logic [7:0]         rx_ff, rx_in;
   logic               ack_ff, ack_in;
   logic               done;
   logic               do_enter;
   logic [TIMER_W-1:0] period;

   // zero period behaves as one tick
   assign period     = (half_period == '0) ? TIMER_W'(1) : half_period;
   assign atimer_dec = (atimer_ff != '0) ? atimer_ff - TIMER_W'(1) : '0;

   always_comb begin
      phase_in  = phase_ff;
      ptimer_in = ptimer_ff;
      atimer_in = atimer_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      mode_in   = mode_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      sden_in   = sden_ff;
      rx_in     = rx_ff;
      ack_in    = ack_ff;
      done      = 1'b0;
      do_enter  = 1'b0;
      enter_ph  = PH_IDLE;

      if (phase_ff == PH_IDLE) begin
         if (item.cmd_valid) begin
            case (item.mode)
               MODE_START: begin
                  do_enter = 1'b1;
                  enter_ph = PH_ST_A;
               end
               MODE_STOP: begin
                  do_enter = 1'b1;
                  enter_ph = PH_SP_A;
               end
               MODE_WRITE: begin
                  do_enter = 1'b1;
                  enter_ph = PH_WR_DATA;
                  shift_in = item.tx_byte;
               end
               MODE_READ_ACK, MODE_READ_NACK: begin
                  do_enter = 1'b1;
                  enter_ph = PH_RD_HIGH;
                  shift_in = 8'h00;
               end
               default: ;  // unknown codes are dropped
            endcase
            if (do_enter) begin
               mode_in = item.mode;
               bit_in  = 3'd0;
            end
         end
      end else if (phase_ff == PH_ACK_POLL) begin
         if (!item.sda_in) begin
            ack_in   = 1'b1;
            do_enter = 1'b1;
            enter_ph = PH_ACK_LOW;
         end else begin
            atimer_in = atimer_dec;
            if (atimer_dec == '0) begin
               ack_in   = 1'b0;
               do_enter = 1'b1;
               enter_ph = PH_ACK_LOW;
            end
         end
      end else if (ptimer_ff > TIMER_W'(1)) begin
         ptimer_in = ptimer_ff - TIMER_W'(1);
      end else begin
         case (phase_ff)
            PH_ST_A:    begin do_enter = 1'b1; enter_ph = PH_ST_B;    end
            PH_ST_B:    begin do_enter = 1'b1; enter_ph = PH_ST_C;    end
            PH_SP_A:    begin do_enter = 1'b1; enter_ph = PH_SP_B;    end
            PH_SP_B:    begin do_enter = 1'b1; enter_ph = PH_SP_C;    end
            PH_WR_DATA: begin do_enter = 1'b1; enter_ph = PH_WR_HIGH; end
            PH_WR_HIGH: begin do_enter = 1'b1; enter_ph = PH_WR_LOW;  end
            PH_RA_DATA: begin do_enter = 1'b1; enter_ph = PH_RA_HIGH; end
            PH_RA_HIGH: begin do_enter = 1'b1; enter_ph = PH_RA_LOW;  end
            PH_WR_LOW: begin
               do_enter = 1'b1;
               if (bit_ff == 3'd7) begin
                  enter_ph = PH_ACK_HIGH;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  enter_ph = PH_WR_DATA;
               end
            end
            PH_ACK_HIGH: begin
               phase_in  = PH_ACK_POLL;
               ptimer_in = '0;
               atimer_in = period;
            end
            PH_RD_HIGH: begin
               shift_in = {shift_ff[6:0], item.sda_in};
               do_enter = 1'b1;
               enter_ph = PH_RD_LOW;
            end
            PH_RD_LOW: begin
               do_enter = 1'b1;
               if (bit_ff == 3'd7) begin
                  rx_in    = shift_ff;
                  enter_ph = PH_RA_DATA;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  enter_ph = PH_RD_HIGH;
               end
            end
            default: begin
               // last phase of a command ends
               phase_in  = PH_IDLE;
               ptimer_in = '0;
               sden_in   = 1'b1;
               done      = 1'b1;
            end
         endcase
      end

      // phase entry: reload timer, set pin levels
      if (do_enter) begin
         phase_in  = enter_ph;
         ptimer_in = period;
         case (enter_ph)
            PH_ST_A:     begin sda_in = 1'b1; scl_in = 1'b1; sden_in = 1'b1; end
            PH_ST_B:     sda_in = 1'b0;
            PH_SP_A:     begin sda_in = 1'b0; sden_in = 1'b1; end
            PH_SP_C:     sda_in = 1'b1;
            PH_WR_DATA:  begin sden_in = 1'b1; sda_in = shift_in[~bit_in]; end
            PH_ACK_HIGH: begin sda_in = 1'b0; sden_in = 1'b0; scl_in = 1'b1; end
            PH_RD_HIGH:  begin sden_in = 1'b0; scl_in = 1'b1; end
            PH_RA_DATA: begin
               sden_in = 1'b1;
               sda_in  = (mode_in == MODE_READ_NACK);
            end
            PH_SP_B, PH_WR_HIGH, PH_RA_HIGH: scl_in = 1'b1;
            PH_ST_C, PH_WR_LOW, PH_ACK_LOW, PH_RD_LOW, PH_RA_LOW: scl_in = 1'b0;
            default: ;
         endcase
      end
   end

   always_comb begin
      result.scl_out   = scl_in;
      result.sda_out   = sda_in;
      result.sda_drive = sden_in;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.rx_byte   = rx_in;
      result.ack_ok    = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ptimer_ff <= '0;
         atimer_ff <= '0;
         bit_ff    <= 3'd0;
         shift_ff  <= 8'h00;
         mode_ff   <= 3'd0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
         sden_ff   <= 1'b1;
         rx_ff     <= 8'h00;
         ack_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         ptimer_ff <= ptimer_in;
         atimer_ff <= atimer_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         mode_ff   <= mode_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
         sden_ff   <= sden_in;
         rx_ff     <= rx_in;
         ack_ff    <= ack_in;
      end
   end

endmodule

/* sv/i2cbe_out_reg.sv */
// ----------------------------------------------------------------------------
// i2cbe_out_reg: response output register
// Holds one tick result until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cbe_out_reg
   import i2cbe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule
